[rtl/ccr_pkg.sv]
package ccr_pkg;

  // field widths
  localparam int COLOR_W = 5;
  localparam int COUNT_W = 6;

  // relabel table size and color range
  localparam int COLOR_SLOTS = 32;
  localparam int MAX_COLORS = 32;

  // operation codes
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_PERM = 2'd1;
  localparam logic [1:0] OP_EMIT = 2'd2;

endpackage

[rtl/ccr_cfg_if.sv]
interface ccr_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] vertex_count;

  modport source (output valid, output vertex_count, input ready);
  modport sink (input valid, input vertex_count, output ready);
endinterface

[rtl/ccr_in_if.sv]
interface ccr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [4:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

[rtl/ccr_out_if.sv]
interface ccr_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] canonical_color;
  logic       last;
  logic       error;

  modport source (output valid, output canonical_color, output last, output error,
                  input ready);
  modport sink (input valid, input canonical_color, input last, input error,
                output ready);
endinterface

[rtl/ccr_ram.sv]
module ccr_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/ccr_relabel.sv]
module ccr_relabel (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clear,
  input  logic                      step,
  input  logic                      restart,
  input  logic                      init_better,
  input  logic [ccr_pkg::COLOR_W-1:0] color,
  input  logic [ccr_pkg::COLOR_W-1:0] best_color,
  output logic [ccr_pkg::COLOR_W-1:0] fresh,
  output logic                      best_we
);
  import ccr_pkg::*;

  logic [COLOR_SLOTS-1:0] relabel_valid;
  logic [COLOR_W-1:0]     relabel_map [COLOR_SLOTS];
  logic [COUNT_W-1:0]     next_new_color;
  logic                   better;
  logic                   stopped;

  logic [COLOR_SLOTS-1:0] valid_cur;
  logic [COUNT_W-1:0]     nnc_cur;
  logic                   better_cur;
  logic                   stop_cur;
  logic                   hit;
  logic                   upd;
  logic                   is_new;
  logic                   better_new;
  logic                   stop_new;

  // state as seen by this entry, fresh at the start of a permutation
  always_comb begin
    valid_cur  = restart ? '0 : relabel_valid;
    nnc_cur    = restart ? '0 : next_new_color;
    better_cur = restart ? init_better : better;
    stop_cur   = restart ? 1'b0 : stopped;
    hit        = valid_cur[color];
    fresh      = hit ? relabel_map[color] : nnc_cur[COLOR_W-1:0];
    upd        = !stop_cur;
    is_new     = upd && !hit;
    stop_new   = stop_cur || (upd && !better_cur && (fresh > best_color));
    better_new = better_cur || (upd && !better_cur && (fresh < best_color));
    best_we    = step && upd && better_new && !stop_new;
  end

  // control state of the running permutation
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      relabel_valid  <= '0;
      next_new_color <= '0;
      better         <= 1'b0;
      stopped        <= 1'b0;
    end else if (step) begin
      relabel_valid  <= valid_cur | (is_new ? (COLOR_SLOTS'(1) << color) : '0);
      next_new_color <= nnc_cur + (is_new ? COUNT_W'(1) : '0);
      better         <= better_new;
      stopped        <= stop_new;
    end
  end

  // relabel map entries, guarded by the valid bits
  always_ff @(posedge clk) begin
    if (step && is_new) begin
      relabel_map[color] <= fresh;
    end
  end

endmodule

[rtl/canonical_coloring_relabel_top.sv]
// Canonical coloring relabeler.
// Channels: cfg writes vertex_count (always ready, write only while idle);
// items carries operation/value words (load color, permutation entry, emit);
// results carries canonical_color, last and error words.
// A load word is written in its accept cycle. For a permutation entry the colors
// memory and the best-coloring memory are read in the accept cycle, and the
// next cycle relabels, compares and writes the best color back.
// An emit word reads one position at a time through the single read port
// of the memories, alternating ST_EMIT_RD and ST_EMIT_WR; ready for items
// drops during that time. The first result enters the output register in
// the first ST_EMIT_WR after the emit word is accepted.
// The output register holds a result while the receiver stalls; the emit
// sequence waits for it, and after the last result the block takes new items
// while that result still waits.
// Reset (rst, synchronous) sets vertex_count to 32 and clears all control
// state; memory contents are not cleared and stay undefined until written.
// After an emit the block returns to the same cleared state, vertex_count kept.
module canonical_coloring_relabel_top #(
  parameter int MAX_VERTICES = 32
) (
  input logic      clk,
  input logic      rst,
  ccr_cfg_if.sink  cfg,
  ccr_in_if.sink   items,
  ccr_out_if.source results
);
  import ccr_pkg::*;

  localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int N_CAP = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_PERM    = 2'd1;
  localparam logic [1:0] ST_EMIT_RD = 2'd2;
  localparam logic [1:0] ST_EMIT_WR = 2'd3;

  logic [1:0]         state;
  logic [COUNT_W-1:0] vertex_count;
  logic [COUNT_W-1:0] n_eff;
  logic [COUNT_W-1:0] load_pointer;
  logic [COUNT_W-1:0] perm_position;
  logic               first_perm_done;
  logic               sticky_error;
  logic [COLOR_W-1:0] v_q;
  logic [COUNT_W-1:0] emit_k;

  logic               out_valid;
  logic [COLOR_W-1:0] out_color;
  logic               out_last;
  logic               out_error;

  logic               in_take;
  logic               out_free;
  logic               v_ok;
  logic               perm_err;
  logic [COLOR_W-1:0] perm_color;
  logic [COLOR_W-1:0] emit_color;
  logic               emit_last;
  logic               emit_done;

  logic               loaded_we;
  logic               loaded_re;
  logic [AW-1:0]      loaded_raddr;
  logic [COLOR_W-1:0] loaded_rd;
  logic               best_re;
  logic [AW-1:0]      best_raddr;
  logic [COLOR_W-1:0] best_rd;
  logic               best_we;
  logic [COLOR_W-1:0] fresh;

  // configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= COUNT_W'(32);
    end else if (cfg.valid) begin
      vertex_count <= cfg.vertex_count;
    end
  end

  // vertex count saturated to the supported range
  always_comb begin
    if (vertex_count == '0) begin
      n_eff = COUNT_W'(1);
    end else if (vertex_count > COUNT_W'(N_CAP)) begin
      n_eff = COUNT_W'(N_CAP);
    end else begin
      n_eff = vertex_count;
    end
  end

  // handshakes
  assign items.ready = (state == ST_IDLE);
  assign in_take     = items.valid && items.ready;
  assign out_free    = !out_valid || results.ready;

  assign results.valid           = out_valid;
  assign results.canonical_color = out_color;
  assign results.last            = out_last;
  assign results.error           = out_error;

  // permutation entry color and error check, emit color and last flag
  always_comb begin
    v_ok       = ({1'b0, v_q} < n_eff);
    perm_color = v_ok ? loaded_rd : '0;
    perm_err   = !v_ok || ({1'b0, perm_color} >= COUNT_W'(MAX_COLORS));
    emit_color = first_perm_done ? best_rd : loaded_rd;
    emit_last  = ((emit_k + COUNT_W'(1)) == n_eff);
    emit_done  = (state == ST_EMIT_WR) && out_free && emit_last;
  end

  // memory ports
  always_comb begin
    loaded_we    = in_take && (items.operation == OP_LOAD) && (load_pointer < n_eff);
    loaded_re    = (in_take && (items.operation == OP_PERM)) || (state == ST_EMIT_RD);
    loaded_raddr = (state == ST_EMIT_RD) ? AW'(emit_k) : AW'(items.value);
    best_re      = loaded_re;
    best_raddr   = (state == ST_EMIT_RD) ? AW'(emit_k) : AW'(perm_position);
  end

  ccr_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (MAX_VERTICES)
  ) u_loaded (
    .clk   (clk),
    .we    (loaded_we),
    .waddr (AW'(load_pointer)),
    .wdata (items.value),
    .re    (loaded_re),
    .raddr (loaded_raddr),
    .rdata (loaded_rd)
  );

  ccr_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (MAX_VERTICES)
  ) u_best (
    .clk   (clk),
    .we    (best_we),
    .waddr (AW'(perm_position)),
    .wdata (fresh),
    .re    (best_re),
    .raddr (best_raddr),
    .rdata (best_rd)
  );

  ccr_relabel u_relabel (
    .clk         (clk),
    .rst         (rst),
    .clear       (emit_done),
    .step        (state == ST_PERM),
    .restart     (perm_position == '0),
    .init_better (!first_perm_done),
    .color       (perm_color),
    .best_color  (best_rd),
    .fresh       (fresh),
    .best_we     (best_we)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_EMIT_WR) && out_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      load_pointer    <= '0;
      perm_position   <= '0;
      first_perm_done <= 1'b0;
      sticky_error    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            unique case (items.operation)
              OP_LOAD: begin
                if (load_pointer < n_eff) begin
                  load_pointer <= load_pointer + COUNT_W'(1);
                end
              end
              OP_PERM: begin
                state <= ST_PERM;
              end
              OP_EMIT: begin
                if (perm_position != '0) begin
                  sticky_error <= 1'b1;
                end
                state <= ST_EMIT_RD;
              end
              default: begin
              end
            endcase
          end
        end
        ST_PERM: begin
          if (perm_err) begin
            sticky_error <= 1'b1;
          end
          if ((perm_position + COUNT_W'(1)) >= n_eff) begin
            perm_position   <= '0;
            first_perm_done <= 1'b1;
          end else begin
            perm_position <= perm_position + COUNT_W'(1);
          end
          state <= ST_IDLE;
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_WR;
        end
        ST_EMIT_WR: begin
          if (out_free) begin
            if (emit_last) begin
              load_pointer    <= '0;
              perm_position   <= '0;
              first_perm_done <= 1'b0;
              sticky_error    <= 1'b0;
              state           <= ST_IDLE;
            end else begin
              state <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take && (items.operation == OP_PERM)) begin
      v_q <= items.value;
    end
    if (in_take && (items.operation == OP_EMIT)) begin
      emit_k <= '0;
    end else if ((state == ST_EMIT_WR) && out_free && !emit_last) begin
      emit_k <= emit_k + COUNT_W'(1);
    end
    if ((state == ST_EMIT_WR) && out_free) begin
      out_color <= emit_color;
      out_last  <= emit_last;
      out_error <= sticky_error;
    end
  end

endmodule
